// File: hdl/cnhp_pkg.sv
// ----------------------------------------------------------------------------
// Control network header parser package
// Shared constants, types and lookup tables.
// ----------------------------------------------------------------------------
package cnhp_pkg;

  localparam int MaxFrameBytes  = 255;
  localparam int ChallengeBytes = 8;
  localparam int QueueDepth     = 2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_REMINDER  = 3'd4;

  localparam logic [3:0] SVC_UNACKD  = 4'd2;
  localparam logic [3:0] SVC_ACK     = 4'd11;
  localparam logic [3:0] SVC_UNKNOWN = 4'd14;

  localparam logic [0:0] CFG_ENH_VERSION = 1'd0;
  localparam logic [0:0] CFG_VER_MASK    = 1'd1;

  // Frame snapshot handed from the byte collector to the decoder
  typedef struct packed {
    logic [7:0]  len;
    logic [15:0] hdr;
    logic [2:0]  fmt;
    logic [14:0] src;
    logic [55:0] dest;
    logic [47:0] dom;
    logic [31:0] tregs;
  } frame_t;

  function automatic logic [2:0] dest_len(input logic [2:0] fmt);
    unique case (fmt)
      3'd2:    dest_len = 3'd2;
      3'd3:    dest_len = 3'd7;
      3'd4:    dest_len = 3'd4;
      default: dest_len = 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] dom_len(input logic [1:0] code);
    unique case (code)
      2'd0: dom_len = 3'd0;
      2'd1: dom_len = 3'd1;
      2'd2: dom_len = 3'd3;
      default: dom_len = 3'd6;
    endcase
  endfunction

  function automatic logic [3:0] svc_lookup(input logic [1:0] pdu, input logic [2:0] typ);
    logic [3:0] r;
    r = SVC_UNKNOWN;
    unique case (pdu)
      2'd0: unique case (typ)
        3'd0: r = 4'd0; 3'd1: r = 4'd1; 3'd2: r = 4'd11;
        3'd4: r = 4'd5; 3'd5: r = 4'd7; default: r = SVC_UNKNOWN;
      endcase
      2'd1: unique case (typ)
        3'd0: r = 4'd3; 3'd2: r = 4'd4; 3'd4: r = 4'd6;
        3'd5: r = 4'd8; default: r = SVC_UNKNOWN;
      endcase
      2'd2: unique case (typ)
        3'd0: r = 4'd9; 3'd1: r = 4'd12; 3'd2: r = 4'd10;
        3'd3: r = 4'd13; default: r = SVC_UNKNOWN;
      endcase
      default: r = SVC_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/cnhp_front.sv
// ----------------------------------------------------------------------------
// Header byte collector
// Tracks the byte position and captures header fields; on the last byte it
// pushes a frame snapshot into the queue.
// ----------------------------------------------------------------------------
module cnhp_front import cnhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic [1:0]   enhanced_version,
  input  logic         q_full,
  output logic         q_push,
  output frame_t       q_data
);

  logic [7:0]  byte_index;
  logic [15:0] hdr;
  logic [2:0]  fmt;
  logic [14:0] src;
  logic [55:0] dest;
  logic [47:0] dom;
  logic [31:0] tregs;

  logic        take;
  logic [7:0]  b;
  logic [15:0] hdr_next;
  logic [2:0]  fmt_next;
  logic [14:0] src_next;
  logic [55:0] dest_next;
  logic [47:0] dom_next;
  logic [31:0] tregs_next;
  logic [7:0]  len_next;
  logic [7:0]  dest_end, h3, r;
  logic [1:0]  th;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // field capture by byte position
  always_comb begin
    hdr_next   = hdr;
    fmt_next   = fmt;
    src_next   = src;
    dest_next  = dest;
    dom_next   = dom;
    tregs_next = tregs;
    b          = data_byte;
    dest_end   = 8'd4 + {5'd0, dest_len(fmt)};
    h3         = dest_end + {5'd0, dom_len(hdr[1:0])};
    r          = byte_index - h3;
    if (hdr[5:4] == 2'd3) th = 2'd0;
    else if (hdr[7:6] == enhanced_version) th = 2'd2;
    else th = 2'd1;
    len_next   = byte_index;
    if (byte_index < 8'(MaxFrameBytes)) begin
      len_next = byte_index + 8'd1;
      if (byte_index == 8'd0) begin
        hdr_next[15:8] = b;
      end else if (byte_index == 8'd1) begin
        hdr_next[7:0] = b;
        fmt_next = {1'b0, b[3:2]};
      end else if (byte_index == 8'd2) begin
        src_next[14:7] = b;
      end else if (byte_index == 8'd3) begin
        src_next[6:0] = b[6:0];
        if (fmt == 3'd2 && !b[7]) fmt_next = 3'd4;
      end else if (byte_index < dest_end) begin
        if (byte_index == 8'd5 && (fmt == 3'd2 || fmt == 3'd4)) b[7] = 1'b0;
        dest_next = {dest[47:0], b};
      end else if (byte_index < h3) begin
        dom_next = {dom[39:0], b};
      end else if (th != 2'd0) begin
        if (r == 8'd0) tregs_next[7:0] = b;
        if (r == 8'd1 && th == 2'd2) tregs_next[15:8] = b;
        if (r == {6'd0, th}) tregs_next[23:16] = b;
        if (hdr[5:4] == 2'd2 && r == {6'd0, th} + 8'(ChallengeBytes))
          tregs_next[31:24] = b;
      end
    end
  end

  assign q_push = take && last_byte;
  assign q_data = '{len: len_next, hdr: hdr_next, fmt: fmt_next, src: src_next,
                    dest: dest_next, dom: dom_next, tregs: tregs_next};

  // frame state, cleared after the last beat
  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      byte_index <= '0;
      hdr <= '0; fmt <= '0; src <= '0; dest <= '0; dom <= '0; tregs <= '0;
    end else if (take) begin
      byte_index <= len_next;
      hdr <= hdr_next; fmt <= fmt_next; src <= src_next;
      dest <= dest_next; dom <= dom_next; tregs <= tregs_next;
    end
  end

endmodule

// File: hdl/cnhp_queue.sv
// ----------------------------------------------------------------------------
// Frame queue
// Short FIFO of frame snapshots between collector and decoder.
// ----------------------------------------------------------------------------
module cnhp_queue import cnhp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output frame_t pop_data
);

  localparam int AW = $clog2(QueueDepth);

  frame_t          mem [QueueDepth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign full      = count == (AW+1)'(QueueDepth);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/cnhp_back.sv
// ----------------------------------------------------------------------------
// Header decoder
// Works out status, service and payload bounds of a frame snapshot and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module cnhp_back import cnhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  frame_t       q_data,
  output logic         q_pop,
  input  logic [1:0]   enhanced_version,
  input  logic [3:0]   valid_version_mask,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [186:0] out_data
);

  logic [2:0]  status;
  logic [3:0]  svc;
  logic [11:0] tx;
  logic [10:0] auth;
  logic [7:0]  poff, plen;
  logic [7:0]  h3;
  logic [1:0]  th, pdu;
  logic [8:0]  nlen;
  logic [7:0]  t0;
  logic [2:0]  typ;
  logic        nlen_pos, nlen_neg, nlen_zero;
  logic [186:0] res;

  always_comb begin
    pdu = q_data.hdr[5:4];
    h3  = 8'd4 + {5'd0, dest_len(q_data.fmt)} + {5'd0, dom_len(q_data.hdr[1:0])};
    if (pdu == 2'd3) th = 2'd0;
    else if (q_data.hdr[7:6] == enhanced_version) th = 2'd2;
    else th = 2'd1;
    nlen = {1'b0, q_data.len} - 9'd2 - {1'b0, h3} - {7'd0, th};
    nlen_neg  = nlen[8];
    nlen_zero = nlen == '0;
    nlen_pos  = !nlen_neg && !nlen_zero;
    t0   = q_data.tregs[7:0];
    typ  = '0;
    status = ST_OK;
    svc = SVC_UNKNOWN; tx = '0; auth = '0; poff = '0; plen = '0;
    if ({1'b0, q_data.len} <= {1'b0, h3} + 9'd2) status = ST_SHORT;
    else if (!valid_version_mask[q_data.hdr[7:6]]) status = ST_BAD_VER;
    if (status == ST_OK) begin
      if (pdu == 2'd3) begin
        svc = SVC_UNACKD;
      end else begin
        tx = (th == 2'd2) ? {t0[3:0], q_data.tregs[15:8]} : {8'd0, t0[3:0]};
        if (pdu == 2'd2) begin
          typ  = {1'b0, t0[5:4]};
          auth = {1'b0, t0[7:6], q_data.tregs[31:24]};
        end else begin
          typ  = t0[6:4];
          auth = {t0[7], q_data.hdr[3:2], 8'd0};
        end
        svc = svc_lookup(pdu, typ);
        if (svc == SVC_UNKNOWN) status = ST_UNKNOWN;
        else if (svc >= 4'd5 && svc <= 4'd8 && nlen_pos && q_data.tregs[23:16] > 8'd8)
          begin
          svc = SVC_UNKNOWN;
          status = ST_REMINDER;
        end
      end
      if (nlen_neg || (nlen_zero && svc != SVC_ACK)) begin
        svc = SVC_UNKNOWN;
        status = ST_SHORT;
      end
      if (status == ST_OK) begin
        poff = h3 + {6'd0, th};
        plen = nlen[7:0];
      end else begin
        svc = SVC_UNKNOWN;
      end
    end
    res = {plen, poff, auth, tx, svc, dom_len(q_data.hdr[1:0]), q_data.dom,
           q_data.dest, q_data.src, q_data.fmt, q_data.hdr, status};
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (q_pop) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data <= res;
  end

endmodule

// File: hdl/control_net_header_parser.sv
// ----------------------------------------------------------------------------
// Control network header parser
//   channel   dir  beat
//   s_axis    in   one frame byte, tlast on the second CRC byte
//   m_axis    out  one decoded header per frame
//   cfg       in   register write, no read-back
// One byte per cycle; the collector accepts whenever the two-entry frame
// queue has room. A frame snapshot enters the queue on the last byte and
// its result then waits in the decoder's output register; a stalled output
// fills the queue and then stalls input. Reset (rst, synchronous) clears
// frame state, queue and output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module control_net_header_parser import cnhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, link_net_header, address_format, source_address, dest_address,
  // domain_id, domain_length, service_type, transaction, auth_info,
  // payload_offset, payload_length (192 bits, top 5 zero)
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  logic [1:0] enhanced_version;
  logic [3:0] valid_version_mask;
  logic       q_full, q_push, q_pop, q_valid;
  frame_t     q_in, q_out;
  logic [186:0] res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enhanced_version   <= 2'd2;
      valid_version_mask <= 4'd5;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENH_VERSION) enhanced_version <= cfg_data[1:0];
      if (cfg_index == CFG_VER_MASK) valid_version_mask <= cfg_data;
    end
  end

  cnhp_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .data_byte (s_axis_tdata), .last_byte (s_axis_tlast),
    .enhanced_version, .q_full, .q_push, .q_data (q_in)
  );

  cnhp_queue u_queue (
    .clk, .rst, .push (q_push), .push_data (q_in), .full (q_full),
    .pop (q_pop), .not_empty (q_valid), .pop_data (q_out)
  );

  cnhp_back u_back (
    .clk, .rst, .q_valid, .q_data (q_out), .q_pop,
    .enhanced_version, .valid_version_mask,
    .out_valid (m_axis_tvalid), .out_ready (m_axis_tready), .out_data (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule

// File: test/tb_control_net_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header parser testbench
// Streams frames of bytes into the parser under random bursts and output
// stalls. A local decoder follows every accepted byte and predicts the one
// header result per frame, which is checked field by field. Both registers
// are swept between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb_control_net_header_parser;
  import cnhp_pkg::*;

  // service codes and PDU kinds the decoder needs by name
  localparam logic [3:0] SVC_RMD_ACKD = 4'd5;
  localparam logic [3:0] SVC_RMM_REQ  = 4'd8;
  localparam logic [1:0] PDU_AUTH     = 2'd2;
  localparam logic [1:0] PDU_APDU     = 2'd3;
  localparam logic [2:0] FMT_SUBNET   = 3'd2;
  localparam logic [2:0] FMT_UID      = 3'd3;
  localparam logic [2:0] FMT_GRP_ACK  = 3'd4;
  localparam int         WatchdogMax  = 20000;

  // result fields, last field first so the packed layout matches tdata
  typedef struct packed {
    logic [7:0]  payload_length;
    logic [7:0]  payload_offset;
    logic [10:0] auth_info;
    logic [11:0] transaction;
    logic [3:0]  service_type;
    logic [2:0]  domain_length;
    logic [47:0] domain_id;
    logic [55:0] dest_address;
    logic [14:0] source_address;
    logic [2:0]  address_format;
    logic [15:0] link_net_header;
    logic [2:0]  status;
  } hdr_result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // data_byte
  logic         s_axis_tlast;   // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;   // status .. payload_length, see hdr_result_t
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [3:0]   cfg_data;

  control_net_header_parser u_top (.*);

  // pending bytes ({last, data}) and predicted headers
  logic [8:0]  byte_q[$];
  hdr_result_t hdr_q[$];
  int          errors;
  int          idle_cycles;
  bit          s_took;
  int          burst_left;
  int          gap_left;
  int          stall_mode;

  // decoder copy of registers and per-frame state
  logic [1:0]  enh_ver;
  logic [3:0]  ver_mask;
  int          frm_pos;
  logic [15:0] hdr_r;
  logic [14:0] src_r;
  logic [2:0]  fmt_r;
  logic [55:0] dst_r;
  logic [47:0] dom_r;
  logic [31:0] trn_r;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int dest_bytes(input logic [2:0] f);
    case (f)
      FMT_SUBNET:  return 2;
      FMT_UID:     return 7;
      FMT_GRP_ACK: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic int domain_bytes(input logic [1:0] code);
    case (code)
      2'd0:    return 0;
      2'd1:    return 1;
      2'd2:    return 3;
      default: return 6;
    endcase
  endfunction

  function automatic int trans_hdr_bytes(input logic [15:0] h, input logic [1:0] enh);
    if (h[5:4] == PDU_APDU) return 0;
    return (h[7:6] == enh) ? 2 : 1;
  endfunction

  function automatic logic [3:0] service_of(input logic [1:0] pdu, input logic [2:0] typ);
    case (pdu)
      2'd0: case (typ)
        3'd0: return 4'd0;  3'd1: return 4'd1;  3'd2: return SVC_ACK;
        3'd4: return 4'd5;  3'd5: return 4'd7;  default: return SVC_UNKNOWN;
      endcase
      2'd1: case (typ)
        3'd0: return 4'd3;  3'd2: return 4'd4;  3'd4: return 4'd6;
        3'd5: return 4'd8;  default: return SVC_UNKNOWN;
      endcase
      2'd2: case (typ)
        3'd0: return 4'd9;  3'd1: return 4'd12; 3'd2: return 4'd10;
        3'd3: return 4'd13; default: return SVC_UNKNOWN;
      endcase
      default: return SVC_UNKNOWN;
    endcase
  endfunction

  // follow one accepted byte; on the last byte queue the decoded header
  task automatic decode_byte(input logic [7:0] b_in, input logic last);
    logic [7:0]  b;
    int          d, h3, r, th, nlen;
    logic [3:0]  hi;
    logic [2:0]  typ;
    hdr_result_t res;
    b = b_in;
    if (frm_pos < MaxFrameBytes) begin
      if (frm_pos == 0) hdr_r[15:8] = b;
      else if (frm_pos == 1) begin
        hdr_r[7:0] = b;
        fmt_r = {1'b0, b[3:2]};
      end else if (frm_pos == 2) src_r[14:7] = b;
      else if (frm_pos == 3) begin
        src_r[6:0] = b[6:0];
        if (fmt_r == FMT_SUBNET && !b[7]) fmt_r = FMT_GRP_ACK;
      end else begin
        d  = dest_bytes(fmt_r);
        h3 = 4 + d + domain_bytes(hdr_r[1:0]);
        if (frm_pos < 4 + d) begin
          // destination node keeps 7 bits
          if (frm_pos == 5 && (fmt_r == FMT_SUBNET || fmt_r == FMT_GRP_ACK)) b[7] = 1'b0;
          dst_r = {dst_r[47:0], b};
        end else if (frm_pos < h3) dom_r = {dom_r[39:0], b};
        else begin
          r  = frm_pos - h3;
          th = trans_hdr_bytes(hdr_r, enh_ver);
          if (th > 0) begin
            if (r == 0) trn_r[7:0] = b;
            if (r == 1 && th == 2) trn_r[15:8] = b;
            if (r == th) trn_r[23:16] = b;
            if (hdr_r[5:4] == PDU_AUTH && r == th + ChallengeBytes) trn_r[31:24] = b;
          end
        end
      end
      frm_pos++;
    end
    if (!last) return;

    // end of frame: build the header result
    res = '0;
    res.service_type    = SVC_UNKNOWN;
    res.link_net_header = hdr_r;
    res.address_format  = fmt_r;
    res.source_address  = src_r;
    res.dest_address    = dst_r;
    res.domain_id       = dom_r;
    res.domain_length   = 3'(domain_bytes(hdr_r[1:0]));
    h3 = 4 + dest_bytes(fmt_r) + domain_bytes(hdr_r[1:0]);
    if (frm_pos - h3 - 2 <= 0) res.status = ST_SHORT;
    else if (!ver_mask[hdr_r[7:6]]) res.status = ST_BAD_VER;
    if (res.status == ST_OK) begin
      th   = trans_hdr_bytes(hdr_r, enh_ver);
      nlen = frm_pos - 2 - h3 - th;
      if (hdr_r[5:4] == PDU_APDU) res.service_type = SVC_UNACKD;
      else begin
        hi = trn_r[7:4];
        res.transaction = (th == 2) ? {trn_r[3:0], trn_r[15:8]} : {8'h0, trn_r[3:0]};
        if (hdr_r[5:4] == PDU_AUTH) begin
          typ = {1'b0, hi[1:0]};
          res.auth_info = {1'b0, hi[3:2], trn_r[31:24]};
        end else begin
          typ = hi[2:0];
          res.auth_info = {hi[3], hdr_r[3:2], 8'h00};
        end
        res.service_type = service_of(hdr_r[5:4], typ);
        if (res.service_type == SVC_UNKNOWN) res.status = ST_UNKNOWN;
        else if (res.service_type >= SVC_RMD_ACKD && res.service_type <= SVC_RMM_REQ
                 && nlen > 0 && trn_r[23:16] > 8'd8) begin
          res.status = ST_REMINDER;
        end
      end
      if (nlen < 0 || (nlen == 0 && res.service_type != SVC_ACK)) res.status = ST_SHORT;
      if (res.status == ST_OK) begin
        res.payload_offset = 8'(h3 + th);
        res.payload_length = 8'(nlen);
      end else res.service_type = SVC_UNKNOWN;
    end
    hdr_q.push_back(res);
    frm_pos = 0; hdr_r = '0; src_r = '0; fmt_r = '0;
    dst_r = '0; dom_r = '0; trn_r = '0;
  endtask

  task automatic check_field(input string name, input logic [55:0] want, input logic [55:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // sender: bursts with gaps, beats change on the falling edge
  always @(negedge clk) begin
    if (rst) s_axis_tvalid <= 1'b0;
    else if (!s_axis_tvalid || s_took) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_q[0][7:0];
        s_axis_tlast  <= byte_q[0][8];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // receiver: stall pattern changes mode now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // monitor: sample both sides at the rising edge
  always @(posedge clk) begin
    hdr_result_t got, want;
    if (!rst) begin
      s_took = s_axis_tvalid && s_axis_tready;
      if (s_took) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        void'(byte_q.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(hdr_result_t)-1:0];
        if (hdr_q.size() == 0) begin
          errors++;
          $display("%0t: header with none expected, actual %p", $time, got);
        end else begin
          want = hdr_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("link_net_header", want.link_net_header, got.link_net_header);
          check_field("address_format", want.address_format, got.address_format);
          check_field("source_address", want.source_address, got.source_address);
          check_field("dest_address", want.dest_address, got.dest_address);
          check_field("domain_id", want.domain_id, got.domain_id);
          check_field("domain_length", want.domain_length, got.domain_length);
          check_field("service_type", want.service_type, got.service_type);
          check_field("transaction", want.transaction, got.transaction);
          check_field("auth_info", want.auth_info, got.auth_info);
          check_field("payload_offset", want.payload_offset, got.payload_offset);
          check_field("payload_length", want.payload_length, got.payload_length);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ENH_VERSION) enh_ver = cfg_data[1:0];
        else ver_mask = cfg_data;
      end
      // watchdog on cycles with no traffic at all
      if (s_took || (m_axis_tvalid && m_axis_tready) || cfg_we) idle_cycles = 0;
      else if (++idle_cycles >= WatchdogMax) begin
        $display("tb_control_net_header_parser NOT OK");
        $finish;
      end
    end
  end

  task automatic push_frame(input logic [7:0] bytes[$]);
    foreach (bytes[i]) byte_q.push_back({i == bytes.size() - 1, bytes[i]});
  endtask

  // build one frame, mostly well formed, sometimes cut short or overlong
  task automatic random_frame();
    logic [7:0] f[$];
    logic [1:0] ver, pdu, dcode, fmt2;
    logic [7:0] node, t0;
    logic [2:0] fmt;
    int         n, pick;
    ver   = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0 && ver_mask != 0)
      while (!ver_mask[ver]) ver = 2'($urandom_range(0, 3));
    pdu   = 2'($urandom_range(0, 3));
    fmt2  = 2'($urandom_range(0, 3));
    dcode = 2'($urandom_range(0, 3));
    node  = 8'($urandom);
    f.push_back(8'($urandom));
    f.push_back({ver, pdu, fmt2, dcode});
    f.push_back(8'($urandom));
    f.push_back(node);
    fmt = (fmt2 == FMT_SUBNET[1:0] && !node[7]) ? FMT_GRP_ACK : {1'b0, fmt2};
    repeat (dest_bytes(fmt) + domain_bytes(dcode)) f.push_back(8'($urandom));
    if (pdu != PDU_APDU) begin
      t0 = 8'($urandom);
      if (pdu != PDU_AUTH && $urandom_range(0, 5) != 0)
        t0[6:4] = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(4, 5));
      f.push_back(t0);
      if (ver == enh_ver) f.push_back(8'($urandom));
    end
    pick = $urandom_range(0, 19);
    n = (pick == 0) ? $urandom_range(9, 40) : (pdu == PDU_AUTH && pick < 6) ?
        $urandom_range(9, 14) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++)
      f.push_back((i == 0 && $urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12)) : 8'($urandom));
    f.push_back(8'($urandom));
    f.push_back(8'($urandom));
    pick = $urandom_range(0, 199);
    if (pick < 20) f = f[0:$urandom_range(0, f.size() - 1)];
    else if (pick == 20) while (f.size() < 256 + $urandom_range(0, 40)) f.push_back(8'($urandom));
    push_frame(f);
  endtask

  task automatic wait_idle();
    wait (byte_q.size() == 0 && hdr_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [1:0] enh_set[5]  = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2};
    logic [3:0] mask_set[5] = '{4'd5, 4'd15, 4'd0, 4'd15, 4'd9};
    int sent;
    errors = 0; idle_cycles = 0; s_took = 0;
    burst_left = 0; gap_left = 0; stall_mode = 0;
    enh_ver = 2'd2; ver_mask = 4'd5;
    frm_pos = 0; hdr_r = '0; src_r = '0; fmt_r = '0;
    dst_r = '0; dom_r = '0; trn_r = '0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: one-byte frame, two frames too short for their header, reminder, bad version
    push_frame('{8'hff});
    push_frame('{8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00});
    push_frame('{8'hff, 8'h3b, 8'hff, 8'hff, 8'hff, 8'h7f, 8'hff, 8'hff, 8'hff});
    push_frame('{8'h80, 8'h00, 8'h01, 8'h81, 8'h05, 8'h43, 8'h09, 8'h00, 8'h00});
    push_frame('{8'h00, 8'h40, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00});
    wait_idle();

    // random phases, each with a register setting; pauses drain all results
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_ENH_VERSION, enh_set[ph]);
      write_reg(CFG_VER_MASK, mask_set[ph]);
      sent = 0;
      // frames of a phase are queued at once, so the queue length counts bytes
      while (sent < 320) begin
        random_frame();
        sent = byte_q.size();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_control_net_header_parser OK");
    else $display("tb_control_net_header_parser NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/cnhp_pkg.sv
hdl/cnhp_front.sv
hdl/cnhp_queue.sv
hdl/cnhp_back.sv
hdl/control_net_header_parser.sv
test/tb_control_net_header_parser.sv
